// ===== rtl/fua_pkg.sv =====
// shared types, constants and defaults of the fu-a fragmenter
package fua_pkg;

  localparam int unsigned LEN_BITS_DEF   = 20;
  localparam int unsigned CHUNK_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned POS_W          = 3;

  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 16'd1024;
  localparam logic [4:0]       FU_A_TYPE       = 5'd28;
  localparam logic [7:0]       FU_START_BIT    = 8'h80;
  localparam logic [7:0]       FU_END_BIT      = 8'h40;
  localparam logic [POS_W-1:0] POS_START_LAST  = 3'd3;
  localparam logic [POS_W-1:0] POS_NAL_HDR     = 3'd4;
  localparam logic [POS_W-1:0] POS_SAT         = 3'd5;
  localparam logic [7:0]       START_LAST_BYTE = 8'h01;
  localparam int unsigned      MIN_PKT_LEN     = 5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic       dg_start;
    logic       dg_end;
    logic       pfx_err;
  } res_t;

  // one request's worth of results, cnt of them valid
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      res;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam res_t ERR_RES = '{data_byte: 8'h00, is_data: 1'b0, dg_start: 1'b0,
                               dg_end: 1'b0, pfx_err: 1'b1};

endpackage

// ===== rtl/fua_ifs.sv =====
// packet byte and datagram byte channel interfaces
interface fua_pkt_if #(
  parameter int unsigned LEN_BITS = fua_pkg::LEN_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [7:0]          byte_value;
  logic                first_byte;
  logic [LEN_BITS-1:0] packet_length;

  modport source (output valid, byte_value, first_byte, packet_length, input ready);
  modport sink   (input valid, byte_value, first_byte, packet_length, output ready);
endinterface

interface fua_dgram_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       datagram_start;
  logic       datagram_end;
  logic       prefix_error;
  logic       last_of_item;

  modport source (output valid, out_byte, is_data, datagram_start, datagram_end,
                  prefix_error, last_of_item, input ready);
  modport sink   (input valid, out_byte, is_data, datagram_start, datagram_end,
                  prefix_error, last_of_item, output ready);
endinterface

// ===== rtl/fua_front.sv =====
// front end: start code check, length tracking and fragment decisions per byte
module fua_front #(
  parameter int unsigned LEN_BITS   = fua_pkg::LEN_BITS_DEF,
  parameter int unsigned CHUNK_BITS = fua_pkg::CHUNK_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fua_pkt_if.sink                   pkt_i,
  input  logic                      cfg_we_i,
  input  logic [fua_pkg::CFG_W-1:0] cfg_wdata_i,
  input  fua_pkg::q_stat_t          q_stat_i,
  output logic                      push_o,
  output fua_pkg::cmd_t             cmd_o
);

  localparam int unsigned W    = (LEN_BITS > CHUNK_BITS) ? LEN_BITS : CHUNK_BITS;
  localparam int unsigned MAXW = (fua_pkg::CFG_W > CHUNK_BITS) ? fua_pkg::CFG_W : CHUNK_BITS;

  logic [fua_pkg::CFG_W-1:0] max_q;
  logic [LEN_BITS-1:0]       rem_q, rem_d;
  logic [fua_pkg::POS_W-1:0] pos_q, pos_d;
  logic [CHUNK_BITS-1:0]     chunk_q, chunk_d;
  logic                      pok_q, pok_d;
  logic                      frag_q, frag_d;
  logic [2:0]                nri_q, nri_d;
  logic [4:0]                typ_q, typ_d;

  logic [MAXW-1:0]       m_w;
  logic [CHUNK_BITS-1:0] eff;
  logic                  accept;
  fua_pkg::cmd_t         cmd;

  // effective chunk limit
  always_comb begin
    m_w = MAXW'(max_q);
    if (max_q == '0) begin
      m_w = MAXW'(1);
    end
    if (m_w > MAXW'((1 << CHUNK_BITS) - 1)) begin
      m_w = MAXW'((1 << CHUNK_BITS) - 1);
    end
    eff = m_w[CHUNK_BITS-1:0];
  end

  assign pkt_i.ready = !q_stat_i.full;
  assign accept      = pkt_i.valid && pkt_i.ready;

  always_comb begin
    logic [7:0]            b;
    logic [LEN_BITS-1:0]   rem_cur;
    logic [LEN_BITS-1:0]   rem_dec;
    logic [fua_pkg::POS_W-1:0] pos_cur;
    logic [7:0]            ind;
    logic                  last;
    logic [W-1:0]          rem_w;
    logic [CHUNK_BITS-1:0] c;

    b       = pkt_i.byte_value;
    rem_d   = rem_q;
    pos_d   = pos_q;
    pok_d   = pok_q;
    frag_d  = frag_q;
    chunk_d = chunk_q;
    nri_d   = nri_q;
    typ_d   = typ_q;
    cmd     = '0;
    ind     = {nri_q, fua_pkg::FU_A_TYPE};
    rem_cur = '0;
    rem_dec = '0;
    pos_cur = '0;
    last    = 1'b0;
    rem_w   = '0;
    c       = '0;

    if (pkt_i.first_byte && (W'(pkt_i.packet_length) < W'(fua_pkg::MIN_PKT_LEN))) begin
      rem_d      = '0;
      cmd.cnt    = 2'd1;
      cmd.res[0] = fua_pkg::ERR_RES;
    end else begin
      if (pkt_i.first_byte) begin
        rem_d   = pkt_i.packet_length;
        pos_d   = '0;
        pok_d   = 1'b1;
        frag_d  = 1'b0;
        chunk_d = '0;
      end
      if (rem_d != '0) begin
        rem_cur = rem_d;
        rem_dec = rem_cur - LEN_BITS'(1);
        rem_d   = rem_dec;
        pos_cur = pos_d;
        if (pos_cur < fua_pkg::POS_SAT) begin
          pos_d = pos_cur + fua_pkg::POS_W'(1);
        end
        if (pos_cur < fua_pkg::POS_START_LAST) begin
          if (b != 8'h00) begin
            pok_d = 1'b0;
          end
        end else if (pos_cur == fua_pkg::POS_START_LAST) begin
          if (b != fua_pkg::START_LAST_BYTE) begin
            pok_d = 1'b0;
          end
          if (!pok_d) begin
            rem_d      = '0;
            cmd.cnt    = 2'd1;
            cmd.res[0] = fua_pkg::ERR_RES;
          end else begin
            frag_d = W'(rem_dec) > W'(eff);
          end
        end else if (pos_cur == fua_pkg::POS_NAL_HDR) begin
          nri_d = b[7:5];
          typ_d = b[4:0];
          if (frag_d) begin
            c          = eff - CHUNK_BITS'(1);
            chunk_d    = c;
            cmd.cnt    = 2'd2;
            cmd.res[0] = '{data_byte: {b[7:5], fua_pkg::FU_A_TYPE}, is_data: 1'b1,
                           dg_start: 1'b1, dg_end: 1'b0, pfx_err: 1'b0};
            cmd.res[1] = '{data_byte: fua_pkg::FU_START_BIT | {3'b000, b[4:0]},
                           is_data: 1'b1, dg_start: 1'b0, dg_end: (c == '0),
                           pfx_err: 1'b0};
          end else begin
            cmd.cnt    = 2'd1;
            cmd.res[0] = '{data_byte: b, is_data: 1'b1, dg_start: 1'b1,
                           dg_end: (rem_dec == '0), pfx_err: 1'b0};
          end
        end else if (frag_d) begin
          if (chunk_d == '0) begin
            rem_w      = W'(rem_cur);
            last       = rem_w <= W'(eff);
            c          = last ? rem_w[CHUNK_BITS-1:0] : eff;
            c          = c - CHUNK_BITS'(1);
            cmd.cnt    = 2'd3;
            cmd.res[0] = '{data_byte: ind, is_data: 1'b1, dg_start: 1'b1,
                           dg_end: 1'b0, pfx_err: 1'b0};
            cmd.res[1] = '{data_byte: {3'b000, typ_q} | (last ? fua_pkg::FU_END_BIT : 8'h00),
                           is_data: 1'b1, dg_start: 1'b0, dg_end: 1'b0, pfx_err: 1'b0};
            cmd.res[2] = '{data_byte: b, is_data: 1'b1, dg_start: 1'b0,
                           dg_end: (c == '0), pfx_err: 1'b0};
          end else begin
            c          = chunk_d - CHUNK_BITS'(1);
            cmd.cnt    = 2'd1;
            cmd.res[0] = '{data_byte: b, is_data: 1'b1, dg_start: 1'b0,
                           dg_end: (c == '0), pfx_err: 1'b0};
          end
          chunk_d = c;
        end else begin
          cmd.cnt    = 2'd1;
          cmd.res[0] = '{data_byte: b, is_data: 1'b1, dg_start: 1'b0,
                         dg_end: (rem_dec == '0), pfx_err: 1'b0};
        end
      end
    end
  end

  assign push_o = accept && (cmd.cnt != 2'd0);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= fua_pkg::MAX_PAYLOAD_RST;
      rem_q   <= '0;
      pos_q   <= '0;
      chunk_q <= '0;
      pok_q   <= 1'b1;
      frag_q  <= 1'b0;
      nri_q   <= '0;
      typ_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept) begin
        rem_q   <= rem_d;
        pos_q   <= pos_d;
        chunk_q <= chunk_d;
        pok_q   <= pok_d;
        frag_q  <= frag_d;
        nri_q   <= nri_d;
        typ_q   <= typ_d;
      end
    end
  end

endmodule

// ===== rtl/fua_queue.sv =====
// short command queue between front and back end
module fua_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fua_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output fua_pkg::cmd_t    head_o,
  output fua_pkg::q_stat_t stat_o
);

  localparam int unsigned CNT_W = $clog2(fua_pkg::QUEUE_DEPTH + 1);

  fua_pkg::cmd_t               mem_q [fua_pkg::QUEUE_DEPTH];
  logic [fua_pkg::QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == fua_pkg::QPTR_W'(fua_pkg::QUEUE_DEPTH - 1)) ? '0
             : wr_q + fua_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == fua_pkg::QPTR_W'(fua_pkg::QUEUE_DEPTH - 1)) ? '0
             : rd_q + fua_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CNT_W'(fua_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/fua_back.sv =====
// back end: expands queued commands into datagram bytes through an output register
module fua_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fua_pkg::cmd_t    head_i,
  input  fua_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  fua_dgram_if.source      dgram_o
);

  logic [1:0]    idx_q;
  logic          vld_q;
  fua_pkg::res_t res_q;
  logic          last_q;
  logic          load;
  logic          is_last;

  assign load    = !q_stat_i.empty && (!vld_q || dgram_o.ready);
  assign is_last = (idx_q == head_i.cnt - 2'd1);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (dgram_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.res[idx_q];
      last_q <= is_last;
    end
  end

  assign dgram_o.valid          = vld_q;
  assign dgram_o.out_byte       = res_q.data_byte;
  assign dgram_o.is_data        = res_q.is_data;
  assign dgram_o.datagram_start = res_q.dg_start;
  assign dgram_o.datagram_end   = res_q.dg_end;
  assign dgram_o.prefix_error   = res_q.pfx_err;
  assign dgram_o.last_of_item   = last_q;

endmodule

// ===== rtl/h264_nal_fua_fragmenter_core.sv =====
// top level of the h.264 fu-a fragmenter
// Takes one packet byte per cycle while the queue has room and gives one
// datagram byte per cycle while the sink is ready. Each accepted byte is checked
// and classified combinationally and leaves 0 to 3 results in a four-entry
// command queue; the output stage drains that queue one result per cycle while
// the sink is ready, so a byte that opens a new fragment (indicator, FU header
// and data) costs three output bytes and the queue absorbs the burst. Sustained
// input rate is one byte per cycle while the output side keeps up.
module h264_nal_fua_fragmenter_core #(
  parameter int unsigned LEN_BITS   = fua_pkg::LEN_BITS_DEF,
  parameter int unsigned CHUNK_BITS = fua_pkg::CHUNK_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fua_pkt_if.sink                   pkt_i,
  fua_dgram_if.source               dgram_o,
  input  logic                      cfg_we_i,
  input  logic [fua_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic             push;
  logic             pop;
  fua_pkg::cmd_t    cmd;
  fua_pkg::cmd_t    head;
  fua_pkg::q_stat_t q_stat;

  fua_front #(
    .LEN_BITS   (LEN_BITS),
    .CHUNK_BITS (CHUNK_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  fua_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  fua_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .dgram_o  (dgram_o)
  );

  // an error marker is a lone result with no datagram flags
  a_err_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dgram_o.valid && !dgram_o.is_data) |->
      (dgram_o.prefix_error && dgram_o.last_of_item &&
       !dgram_o.datagram_start && !dgram_o.datagram_end))
    else $error("malformed error marker");

  // no request is written into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue overflow");

  // a short packet start always yields a command
  a_short_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_i.valid && pkt_i.ready && pkt_i.first_byte &&
     (pkt_i.packet_length < LEN_BITS'(fua_pkg::MIN_PKT_LEN))) |-> push)
    else $error("short packet without error marker");

  // the queue never pops while empty
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule

// ===== tb/h264_nal_fua_fragmenter_core_tb.sv =====
// self-checking testbench for the fu-a fragmenter core: predicts datagram bytes per packet byte
module h264_nal_fua_fragmenter_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_BYTES  = 24;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned CHUNK_CAP    = (1 << fua_pkg::CHUNK_BITS_DEF) - 1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       dg_start;
    logic       dg_end;
    logic       pfx_err;
    logic       last;
  } dgram_t;

  typedef logic [7:0] byte_q_t [$];

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [fua_pkg::CFG_W-1:0] cfg_wdata_i;

  fua_pkt_if #(.LEN_BITS(fua_pkg::LEN_BITS_DEF)) pkt_bus ();
  fua_dgram_if                                   dg_bus ();

  h264_nal_fua_fragmenter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt_bus.sink),
    .dgram_o     (dg_bus.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  logic [fua_pkg::CFG_W-1:0]        max_payload_m;
  int unsigned                      pos_m;
  logic [fua_pkg::LEN_BITS_DEF-1:0] remain_m;
  int unsigned                      chunk_m;
  bit                               prefix_ok_m;
  bit                               frag_m;
  logic [2:0]                       nri_m;
  logic [4:0]                       type_m;

  dgram_t      expected_dgrams [$];
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned bytes_taken;
  int unsigned data_cnt;
  int unsigned marker_cnt;
  int unsigned settings_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req_cnt;
  int unsigned hold_seen_cnt;
  int unsigned hold_left;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL h264_nal_fua_fragmenter_core");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt = hold_req_cnt;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      dg_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      dg_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && dg_bus.valid && dg_bus.ready) check_dgram();
  end

  function automatic int unsigned payload_limit();
    int unsigned m;
    m = 32'(max_payload_m);
    if (m == 0) m = 1;
    if (m > CHUNK_CAP) m = CHUNK_CAP;
    return m;
  endfunction

  function automatic dgram_t make_res(input logic [7:0] b, input bit data, input bit s,
                                      input bit e, input bit err);
    return '{out_byte: b, is_data: data, dg_start: s, dg_end: e, pfx_err: err, last: 1'b0};
  endfunction

  function automatic void reset_model();
    max_payload_m = fua_pkg::MAX_PAYLOAD_RST;
    pos_m         = 0;
    remain_m      = '0;
    chunk_m       = 0;
    prefix_ok_m   = 1'b1;
    frag_m        = 1'b0;
    nri_m         = '0;
    type_m        = '0;
  endfunction

  // returns 1 when the byte belongs to a packet
  function automatic bit predict_dgrams(input logic [7:0] b, input bit first,
                                        input logic [fua_pkg::LEN_BITS_DEF-1:0] plen);
    dgram_t      res [3];
    int          n;
    int unsigned pos;
    int unsigned incl;
    logic [7:0]  ind;
    bit          in_pkt;
    bit          last_chunk;
    n      = 0;
    in_pkt = 1'b1;
    if (first && plen < fua_pkg::MIN_PKT_LEN) begin
      remain_m = '0;
      res[n]   = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      n++;
    end else begin
      if (first) begin
        remain_m    = plen;
        pos_m       = 0;
        prefix_ok_m = 1'b1;
        frag_m      = 1'b0;
        chunk_m     = 0;
      end
      if (remain_m == 0) begin
        in_pkt = 1'b0;
      end else begin
        remain_m--;
        pos = pos_m;
        if (pos_m < fua_pkg::POS_SAT) pos_m++;
        ind = {nri_m, fua_pkg::FU_A_TYPE};
        if (pos < fua_pkg::POS_START_LAST) begin
          if (b != 8'h00) prefix_ok_m = 1'b0;
        end else if (pos == fua_pkg::POS_START_LAST) begin
          if (b != fua_pkg::START_LAST_BYTE) prefix_ok_m = 1'b0;
          if (!prefix_ok_m) begin
            remain_m = '0;
            res[n]   = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            n++;
          end else begin
            frag_m = (32'(remain_m) > payload_limit());
          end
        end else if (pos == fua_pkg::POS_NAL_HDR) begin
          nri_m  = b[7:5];
          type_m = b[4:0];
          if (frag_m) begin
            chunk_m = payload_limit() - 1;
            res[n]  = make_res({b[7:5], fua_pkg::FU_A_TYPE}, 1'b1, 1'b1, 1'b0, 1'b0);
            n++;
            res[n]  = make_res(fua_pkg::FU_START_BIT | {3'b000, type_m}, 1'b1, 1'b0,
                               chunk_m == 0, 1'b0);
            n++;
          end else begin
            res[n] = make_res(b, 1'b1, 1'b1, remain_m == 0, 1'b0);
            n++;
          end
        end else if (frag_m) begin
          if (chunk_m == 0) begin
            incl       = 32'(remain_m) + 1;
            last_chunk = (incl <= payload_limit());
            chunk_m    = last_chunk ? incl : payload_limit();
            res[n]     = make_res(ind, 1'b1, 1'b1, 1'b0, 1'b0);
            n++;
            res[n]     = make_res({3'b000, type_m} |
                                  (last_chunk ? fua_pkg::FU_END_BIT : 8'h00),
                                  1'b1, 1'b0, 1'b0, 1'b0);
            n++;
          end
          chunk_m--;
          res[n] = make_res(b, 1'b1, 1'b0, chunk_m == 0, 1'b0);
          n++;
        end else begin
          res[n] = make_res(b, 1'b1, 1'b0, remain_m == 0, 1'b0);
          n++;
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_dgrams.push_back(res[i]);
    return in_pkt;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
  endtask

  task automatic check_dgram();
    dgram_t got;
    dgram_t want;
    got = '{out_byte: dg_bus.out_byte, is_data: dg_bus.is_data,
            dg_start: dg_bus.datagram_start, dg_end: dg_bus.datagram_end,
            pfx_err: dg_bus.prefix_error, last: dg_bus.last_of_item};
    if (got.is_data) data_cnt++;
    else marker_cnt++;
    if (expected_dgrams.size() == 0) begin
      report_mismatch("result with nothing expected", 32'(got), 0);
    end else begin
      want = expected_dgrams.pop_front();
      if (got.out_byte != want.out_byte)
        report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      if (got.is_data != want.is_data)
        report_mismatch("is_data", 32'(got.is_data), 32'(want.is_data));
      if (got.dg_start != want.dg_start)
        report_mismatch("datagram_start", 32'(got.dg_start), 32'(want.dg_start));
      if (got.dg_end != want.dg_end)
        report_mismatch("datagram_end", 32'(got.dg_end), 32'(want.dg_end));
      if (got.pfx_err != want.pfx_err)
        report_mismatch("prefix_error", 32'(got.pfx_err), 32'(want.pfx_err));
      if (got.last != want.last)
        report_mismatch("last_of_item", 32'(got.last), 32'(want.last));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit first,
                           input logic [fua_pkg::LEN_BITS_DEF-1:0] plen);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt_bus.valid         <= 1'b1;
    pkt_bus.byte_value    <= b;
    pkt_bus.first_byte    <= first;
    pkt_bus.packet_length <= plen;
    @(posedge clk_i);
    while (!pkt_bus.ready) @(posedge clk_i);
    if (predict_dgrams(b, first, plen)) bytes_taken++;
  endtask

  task automatic send_packet(input byte_q_t bytes,
                             input logic [fua_pkg::LEN_BITS_DEF-1:0] plen);
    foreach (bytes[i])
      send_byte(bytes[i], i == 0, (i == 0) ? plen : fua_pkg::LEN_BITS_DEF'($urandom));
  endtask

  task automatic go_quiet();
    pkt_bus.valid <= 1'b0;
    while (expected_dgrams.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_payload(input logic [fua_pkg::CFG_W-1:0] value);
    go_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    max_payload_m  = value;
    settings_cnt++;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_random_packet();
    int unsigned                      kind;
    int unsigned                      ulen;
    int unsigned                      nsend;
    int unsigned                      idx;
    int unsigned                      span;
    logic [fua_pkg::LEN_BITS_DEF-1:0] plen;
    byte_q_t                          bytes;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), 1'b0, fua_pkg::LEN_BITS_DEF'($urandom));
    end else if (kind < 14) begin
      send_byte(8'($urandom), 1'b1,
                fua_pkg::LEN_BITS_DEF'($urandom_range(fua_pkg::MIN_PKT_LEN - 1)));
    end else begin
      span = 3 * payload_limit() + 2;
      if (span > 18) span = 18;
      ulen  = $urandom_range(1, span);
      bytes = '{8'h00, 8'h00, 8'h00, fua_pkg::START_LAST_BYTE};
      if (kind < 26) begin
        idx        = $urandom_range(3);
        bytes[idx] = bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < ulen; i++) bytes.push_back(8'($urandom));
      plen = fua_pkg::LEN_BITS_DEF'(bytes.size());
      if (kind >= 92) begin
        plen = fua_pkg::LEN_BITS_DEF'($urandom_range(32'(plen) + 1,
                                                     (1 << fua_pkg::LEN_BITS_DEF) - 1));
      end else if (kind >= 84) begin
        nsend = $urandom_range(1, bytes.size() - 1);
        while (bytes.size() > nsend) void'(bytes.pop_back());
      end
      send_packet(bytes, plen);
      if (kind >= 76 && kind < 84)
        repeat ($urandom_range(1, 2))
          send_byte(8'($urandom), 1'b0, fua_pkg::LEN_BITS_DEF'($urandom));
    end
  endtask

  task automatic test_stray_bytes();
    send_byte(8'hFF, 1'b0, '1);
    send_byte(8'h00, 1'b0, '0);
  endtask

  task automatic test_short_packets();
    send_byte(8'h00, 1'b1, '0);
    send_byte(8'hFF, 1'b1, fua_pkg::LEN_BITS_DEF'(fua_pkg::MIN_PKT_LEN - 1));
  endtask

  task automatic test_bad_start_code();
    send_packet('{8'h00, 8'h80, 8'h00, fua_pkg::START_LAST_BYTE, 8'h65},
                fua_pkg::LEN_BITS_DEF'(5));
    send_packet('{8'h00, 8'h00, 8'h00, 8'h07}, fua_pkg::LEN_BITS_DEF'(5));
  endtask

  task automatic test_restart_mid_unit();
    send_packet('{8'h00, 8'h00, 8'h00, fua_pkg::START_LAST_BYTE, 8'h7C}, '1);
    send_packet('{8'h00, 8'h00, 8'h00, fua_pkg::START_LAST_BYTE, 8'hFF, 8'h00},
                fua_pkg::LEN_BITS_DEF'(6));
  endtask

  task automatic test_output_stall();
    byte_q_t bytes;
    write_max_payload(16'd1);
    set_idling(0, 0);
    bytes = '{8'h00, 8'h00, 8'h00, fua_pkg::START_LAST_BYTE, 8'h65};
    repeat (15) bytes.push_back(8'($urandom));
    hold_req_cnt++;
    send_packet(bytes, fua_pkg::LEN_BITS_DEF'(bytes.size()));
    go_quiet();
  endtask

  task automatic run_random_phase(input logic [fua_pkg::CFG_W-1:0] limit);
    int unsigned target;
    write_max_payload(limit);
    target = bytes_taken + PHASE_BYTES;
    while (bytes_taken < target) send_random_packet();
  endtask

  task automatic test_random_traffic();
    set_idling(25, 70);
    run_random_phase(16'd0);
    run_random_phase(16'd2);
    set_idling(70, 25);
    run_random_phase(16'd3);
    run_random_phase(16'hFFFF);
    run_random_phase(fua_pkg::CFG_W'($urandom_range(4, 12)));
    set_idling(0, 0);
    run_random_phase(16'd1);
    run_random_phase(fua_pkg::MAX_PAYLOAD_RST);
    run_random_phase(fua_pkg::CFG_W'($urandom_range(2, 8)));
  endtask

  initial begin
    rst_ni                = 1'b0;
    pkt_bus.valid         = 1'b0;
    pkt_bus.byte_value    = '0;
    pkt_bus.first_byte    = 1'b0;
    pkt_bus.packet_length = '0;
    dg_bus.ready          = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    reset_model();
    set_idling(25, 70);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_stray_bytes();
    test_short_packets();
    test_bad_start_code();
    test_restart_mid_unit();
    test_output_stall();
    test_random_traffic();
    go_quiet();

    if (expected_dgrams.size() != 0)
      report_mismatch("results never arrived", 0, 32'(expected_dgrams.size()));
    $display("covered %0d packet bytes, %0d datagram bytes and %0d error markers",
             bytes_taken, data_cnt, marker_cnt);
    $display("over %0d payload limit writes, three idling mixes and one long output stall",
             settings_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS h264_nal_fua_fragmenter_core");
    end else begin
      $display("FAIL h264_nal_fua_fragmenter_core");
    end
    $finish;
  end

endmodule
